FILE: hdl/ray_triangle_hit_test_defines.svh
// Assertion helpers used by the hit test top level.
`ifndef RAY_TRIANGLE_HIT_TEST_DEFINES_SVH
`define RAY_TRIANGLE_HIT_TEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RTH_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RTH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/rth_pkg.sv
`timescale 1ns / 1ps
package rth_pkg;

   localparam int COORD_BITS   = 20;
   localparam int FRAC_BITS    = 10;
   localparam int VEC_BITS     = 3 * COORD_BITS;
   localparam int TAG_BITS     = 12;
   localparam int FIX_BITS     = 31;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int QUO_BITS     = FIX_BITS + FRAC_BITS;
   localparam int WIDE_BITS    = 64;
   localparam int CSR_IDX_BITS = 2;

   // camera register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CAMERA_X = 2'd0,
      CSR_CAMERA_Y = 2'd1,
      CSR_CAMERA_Z = 2'd2
   } csr_index_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [FIX_BITS-1:0]   fix_type;
   typedef logic signed [WIDE_BITS-1:0]  wide_type;

   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } cvec_type;

   typedef struct packed {
      diff_type z;
      diff_type y;
      diff_type x;
   } dvec_type;

   typedef struct packed {
      fix_type z;
      fix_type y;
      fix_type x;
   } fvec_type;

   // per-item payload that rides along the whole pipe
   typedef struct packed {
      cvec_type            a;
      cvec_type            b;
      cvec_type            c;
      cvec_type            d;
      dvec_type            ab;
      dvec_type            bc;
      dvec_type            ca;
      fvec_type            n;
      logic [TAG_BITS-1:0] px;
      logic [TAG_BITS-1:0] py;
   } item_type;

   // front end -> divider
   typedef struct packed {
      item_type            item;
      logic [FIX_BITS-1:0] num_mag;
      logic [FIX_BITS-1:0] den_mag;
      logic                neg;
      logic                den_zero;
   } div_in_type;

   // divider -> side tests
   typedef struct packed {
      item_type            item;
      logic [QUO_BITS-1:0] quo;
      logic                neg;
      logic                den_zero;
   } div_out_type;

   localparam fix_type FIX_MAX = fix_type'({1'b0, {(FIX_BITS-1){1'b1}}});
   localparam fix_type FIX_MIN = fix_type'({1'b1, {(FIX_BITS-1){1'b0}}});

   function automatic fix_type sat_fix(input wide_type v);
      if (v > wide_type'(FIX_MAX)) begin
         return FIX_MAX;
      end else if (v < wide_type'(FIX_MIN)) begin
         return FIX_MIN;
      end
      return fix_type'(v[FIX_BITS-1:0]);
   endfunction

   // floor shift by the fraction bits, then saturate
   function automatic fix_type rescale(input wide_type v);
      return sat_fix(v >>> FRAC_BITS);
   endfunction

   function automatic cvec_type unpack(input logic [VEC_BITS-1:0] w);
      cvec_type r;
      r.x = w[COORD_BITS-1:0];
      r.y = w[2*COORD_BITS-1:COORD_BITS];
      r.z = w[VEC_BITS-1:2*COORD_BITS];
      return r;
   endfunction

   function automatic dvec_type vdiff(input cvec_type a, input cvec_type b);
      dvec_type r;
      r.x = diff_type'(a.x) - diff_type'(b.x);
      r.y = diff_type'(a.y) - diff_type'(b.y);
      r.z = diff_type'(a.z) - diff_type'(b.z);
      return r;
   endfunction

endpackage

FILE: hdl/rth_if.sv
`timescale 1ns / 1ps
// Ray beat channel
interface rth_req_if import rth_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VEC_BITS-1:0] vertex_a;
   logic [VEC_BITS-1:0] vertex_b;
   logic [VEC_BITS-1:0] vertex_c;
   logic [VEC_BITS-1:0] ray_direction;
   logic [TAG_BITS-1:0] pixel_x;
   logic [TAG_BITS-1:0] pixel_y;

   modport source (output valid, vertex_a, vertex_b, vertex_c, ray_direction,
                   pixel_x, pixel_y, input ready);
   modport sink   (input valid, vertex_a, vertex_b, vertex_c, ray_direction,
                   pixel_x, pixel_y, output ready);
endinterface

// Result beat channel
interface rth_rsp_if import rth_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                hit;
   logic [TAG_BITS-1:0] out_pixel_x;
   logic [TAG_BITS-1:0] out_pixel_y;

   modport source (output valid, hit, out_pixel_x, out_pixel_y, input ready);
   modport sink   (input valid, hit, out_pixel_x, out_pixel_y, output ready);
endinterface

FILE: hdl/rth_front.sv
`timescale 1ns / 1ps
// Normal and plane terms: n = AB x AC, num = n.A - n.P, den = n.D.
module rth_front import rth_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [VEC_BITS-1:0] vertex_a,
   input  logic [VEC_BITS-1:0] vertex_b,
   input  logic [VEC_BITS-1:0] vertex_c,
   input  logic [VEC_BITS-1:0] ray_direction,
   input  logic [TAG_BITS-1:0] pixel_x,
   input  logic [TAG_BITS-1:0] pixel_y,
   input  cvec_type            camera,
   output logic                out_valid,
   output div_in_type          out_div
);

   typedef logic signed [2*DIFF_BITS-1:0]        nprod_type;
   typedef logic signed [FIX_BITS+COORD_BITS-1:0] dprod_type;

   logic       s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   item_type   s1_item_in;
   item_type   s3_item_in;
   item_type   s1_item_ff, s2_item_ff, s3_item_ff, s4_item_ff, s5_item_ff;
   dvec_type   s1_ac_in, s1_ac_ff;
   nprod_type  s2_p_ff [6];
   fvec_type   s3_n_in;
   dprod_type  s4_pa_ff [3];
   dprod_type  s4_pp_ff [3];
   dprod_type  s4_pd_ff [3];
   fix_type    s5_da_ff, s5_dp_ff, s5_dd_ff;
   fix_type    num, den;
   div_in_type s6_in, s6_ff;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // stage 1: unpack and edge vectors
   always_comb begin
      s1_item_in    = '0;
      s1_item_in.a  = unpack(vertex_a);
      s1_item_in.b  = unpack(vertex_b);
      s1_item_in.c  = unpack(vertex_c);
      s1_item_in.d  = unpack(ray_direction);
      s1_item_in.ab = vdiff(s1_item_in.b, s1_item_in.a);
      s1_item_in.bc = vdiff(s1_item_in.c, s1_item_in.b);
      s1_item_in.ca = vdiff(s1_item_in.a, s1_item_in.c);
      s1_item_in.px = pixel_x;
      s1_item_in.py = pixel_y;
      s1_ac_in      = vdiff(s1_item_in.c, s1_item_in.a);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff <= s1_item_in;
         s1_ac_ff   <= s1_ac_in;
      end
   end

   // stage 2: cross product partial products
   always_ff @(posedge clock) begin
      if (en) begin
         s2_item_ff <= s1_item_ff;
         s2_p_ff[0] <= s1_item_ff.ab.y * s1_ac_ff.z;
         s2_p_ff[1] <= s1_item_ff.ab.z * s1_ac_ff.y;
         s2_p_ff[2] <= s1_item_ff.ab.z * s1_ac_ff.x;
         s2_p_ff[3] <= s1_item_ff.ab.x * s1_ac_ff.z;
         s2_p_ff[4] <= s1_item_ff.ab.x * s1_ac_ff.y;
         s2_p_ff[5] <= s1_item_ff.ab.y * s1_ac_ff.x;
      end
   end

   // stage 3: normal
   always_comb begin
      s3_n_in.x    = rescale(wide_type'(s2_p_ff[0]) - wide_type'(s2_p_ff[1]));
      s3_n_in.y    = rescale(wide_type'(s2_p_ff[2]) - wide_type'(s2_p_ff[3]));
      s3_n_in.z    = rescale(wide_type'(s2_p_ff[4]) - wide_type'(s2_p_ff[5]));
      s3_item_in   = s2_item_ff;
      s3_item_in.n = s3_n_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_item_ff <= s3_item_in;
      end
   end

   // stage 4: dot product terms against A, P and D
   always_ff @(posedge clock) begin
      if (en) begin
         s4_item_ff  <= s3_item_ff;
         s4_pa_ff[0] <= s3_item_ff.n.x * s3_item_ff.a.x;
         s4_pa_ff[1] <= s3_item_ff.n.y * s3_item_ff.a.y;
         s4_pa_ff[2] <= s3_item_ff.n.z * s3_item_ff.a.z;
         s4_pp_ff[0] <= s3_item_ff.n.x * camera.x;
         s4_pp_ff[1] <= s3_item_ff.n.y * camera.y;
         s4_pp_ff[2] <= s3_item_ff.n.z * camera.z;
         s4_pd_ff[0] <= s3_item_ff.n.x * s3_item_ff.d.x;
         s4_pd_ff[1] <= s3_item_ff.n.y * s3_item_ff.d.y;
         s4_pd_ff[2] <= s3_item_ff.n.z * s3_item_ff.d.z;
      end
   end

   // stage 5: sums, rescaled
   always_ff @(posedge clock) begin
      if (en) begin
         s5_item_ff <= s4_item_ff;
         s5_da_ff   <= rescale(wide_type'(s4_pa_ff[0]) + wide_type'(s4_pa_ff[1])
                               + wide_type'(s4_pa_ff[2]));
         s5_dp_ff   <= rescale(wide_type'(s4_pp_ff[0]) + wide_type'(s4_pp_ff[1])
                               + wide_type'(s4_pp_ff[2]));
         s5_dd_ff   <= rescale(wide_type'(s4_pd_ff[0]) + wide_type'(s4_pd_ff[1])
                               + wide_type'(s4_pd_ff[2]));
      end
   end

   // stage 6: numerator, and sign/magnitude split for the divider
   always_comb begin
      num               = sat_fix(wide_type'(s5_da_ff) - wide_type'(s5_dp_ff));
      den               = s5_dd_ff;
      s6_in.item        = s5_item_ff;
      s6_in.num_mag     = num[FIX_BITS-1] ? {FIX_BITS{1'b0}} - num : num;
      s6_in.den_mag     = den[FIX_BITS-1] ? {FIX_BITS{1'b0}} - den : den;
      s6_in.neg         = num[FIX_BITS-1] ^ den[FIX_BITS-1];
      s6_in.den_zero    = (den == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_ff <= s6_in;
      end
   end

   assign out_valid = s6_valid_ff;
   assign out_div   = s6_ff;

endmodule

FILE: hdl/rth_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, magnitudes only.
module rth_divider import rth_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  div_in_type  in_div,
   output logic        out_valid,
   output div_out_type out_div
);

   typedef struct packed {
      item_type            item;
      logic [QUO_BITS-1:0] dvd;
      logic [QUO_BITS-1:0] quo;
      logic [FIX_BITS-1:0] rem;
      logic [FIX_BITS-1:0] den;
      logic                neg;
      logic                den_zero;
   } div_stage_type;

   div_stage_type seed;
   div_stage_type st_ff [QUO_BITS];
   logic          st_valid_ff [QUO_BITS];

   // dividend is |num| scaled by the fraction bits
   always_comb begin
      seed.item     = in_div.item;
      seed.dvd      = {in_div.num_mag, {FRAC_BITS{1'b0}}};
      seed.quo      = '0;
      seed.rem      = '0;
      seed.den      = in_div.den_mag;
      seed.neg      = in_div.neg;
      seed.den_zero = in_div.den_zero;
   end

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_step
      div_stage_type     src;
      div_stage_type     st_in;
      logic              src_valid;
      logic [FIX_BITS:0] trial;

      if (g == 0) begin : g_first
         assign src_valid = in_valid;
         assign src       = seed;
      end else begin : g_rest
         assign src_valid = st_valid_ff[g-1];
         assign src       = st_ff[g-1];
      end

      // shift in the next dividend bit, subtract if it fits
      always_comb begin
         st_in = src;
         trial = {src.rem, src.dvd[QUO_BITS-1-g]};
         if (trial >= {1'b0, src.den}) begin
            st_in.rem                = FIX_BITS'(trial - {1'b0, src.den});
            st_in.quo[QUO_BITS-1-g]  = 1'b1;
         end else begin
            st_in.rem = FIX_BITS'(trial);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[g] <= 1'b0;
         end else if (en) begin
            st_valid_ff[g] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[g] <= st_in;
         end
      end
   end

   assign out_valid        = st_valid_ff[QUO_BITS-1];
   assign out_div.item     = st_ff[QUO_BITS-1].item;
   assign out_div.quo      = st_ff[QUO_BITS-1].quo;
   assign out_div.neg      = st_ff[QUO_BITS-1].neg;
   assign out_div.den_zero = st_ff[QUO_BITS-1].den_zero;

endmodule

FILE: hdl/rth_side_test.sv
`timescale 1ns / 1ps
// Hit point Q = P + t*D and the edge-side sign tests against edges AB, BC and CA.
module rth_side_test import rth_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  div_out_type         in_div,
   input  cvec_type            camera,
   output logic                out_valid,
   output logic                out_hit,
   output logic [TAG_BITS-1:0] out_px,
   output logic [TAG_BITS-1:0] out_py
);

   typedef logic signed [COORD_BITS+FIX_BITS-1:0] tprod_type;
   typedef logic signed [DIFF_BITS+FIX_BITS-1:0]  eprod_type;
   typedef logic signed [2*FIX_BITS-1:0]          nprod_type;

   localparam logic [QUO_BITS-1:0] NEG_LIMIT = QUO_BITS'(1) << (FIX_BITS - 1);
   localparam logic [QUO_BITS-1:0] POS_LIMIT = NEG_LIMIT - QUO_BITS'(1);

   logic      e1_valid_ff, e2_valid_ff, e3_valid_ff, e4_valid_ff;
   logic      e5_valid_ff, e6_valid_ff, e7_valid_ff, e8_valid_ff;
   item_type  e1_item_ff, e2_item_ff, e3_item_ff, e4_item_ff;
   item_type  e5_item_ff, e6_item_ff, e7_item_ff;
   logic      e1_ok_ff, e2_ok_ff, e3_ok_ff, e4_ok_ff, e5_ok_ff, e6_ok_ff, e7_ok_ff;
   fix_type   e1_t_in, e1_t_ff;
   tprod_type e2_p_ff [3];
   fvec_type  e3_q_in, e3_q_ff;
   fvec_type  e4_vq_ff [3];
   dvec_type  side_v [3];
   eprod_type e5_p_ff [3][6];
   fvec_type  e6_x_ff [3];
   nprod_type e7_p_ff [3][3];
   logic      side_ok [3];
   logic      e8_hit_ff;
   logic [TAG_BITS-1:0] e8_px_ff, e8_py_ff;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
         e3_valid_ff <= 1'b0;
         e4_valid_ff <= 1'b0;
         e5_valid_ff <= 1'b0;
         e6_valid_ff <= 1'b0;
         e7_valid_ff <= 1'b0;
         e8_valid_ff <= 1'b0;
      end else if (en) begin
         e1_valid_ff <= in_valid;
         e2_valid_ff <= e1_valid_ff;
         e3_valid_ff <= e2_valid_ff;
         e4_valid_ff <= e3_valid_ff;
         e5_valid_ff <= e4_valid_ff;
         e6_valid_ff <= e5_valid_ff;
         e7_valid_ff <= e6_valid_ff;
         e8_valid_ff <= e7_valid_ff;
      end
   end

   // stage 1: signed, saturated t
   always_comb begin
      if (in_div.neg) begin
         if (in_div.quo > NEG_LIMIT) begin
            e1_t_in = FIX_MIN;
         end else begin
            e1_t_in = {FIX_BITS{1'b0}} - in_div.quo[FIX_BITS-1:0];
         end
      end else begin
         if (in_div.quo > POS_LIMIT) begin
            e1_t_in = FIX_MAX;
         end else begin
            e1_t_in = in_div.quo[FIX_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_item_ff <= in_div.item;
         e1_ok_ff   <= !in_div.den_zero;
         e1_t_ff    <= e1_t_in;
      end
   end

   // stage 2: D * t
   always_ff @(posedge clock) begin
      if (en) begin
         e2_item_ff <= e1_item_ff;
         e2_ok_ff   <= e1_ok_ff;
         e2_p_ff[0] <= e1_item_ff.d.x * e1_t_ff;
         e2_p_ff[1] <= e1_item_ff.d.y * e1_t_ff;
         e2_p_ff[2] <= e1_item_ff.d.z * e1_t_ff;
      end
   end

   // stage 3: hit point
   always_comb begin
      e3_q_in.x = sat_fix(wide_type'(camera.x) + wide_type'(rescale(wide_type'(e2_p_ff[0]))));
      e3_q_in.y = sat_fix(wide_type'(camera.y) + wide_type'(rescale(wide_type'(e2_p_ff[1]))));
      e3_q_in.z = sat_fix(wide_type'(camera.z) + wide_type'(rescale(wide_type'(e2_p_ff[2]))));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e3_item_ff <= e2_item_ff;
         e3_ok_ff   <= e2_ok_ff;
         e3_q_ff    <= e3_q_in;
      end
   end

   // stage 4: Q minus each vertex
   always_ff @(posedge clock) begin
      if (en) begin
         e4_item_ff    <= e3_item_ff;
         e4_ok_ff      <= e3_ok_ff;
         e4_vq_ff[0].x <= sat_fix(wide_type'(e3_q_ff.x) - wide_type'(e3_item_ff.a.x));
         e4_vq_ff[0].y <= sat_fix(wide_type'(e3_q_ff.y) - wide_type'(e3_item_ff.a.y));
         e4_vq_ff[0].z <= sat_fix(wide_type'(e3_q_ff.z) - wide_type'(e3_item_ff.a.z));
         e4_vq_ff[1].x <= sat_fix(wide_type'(e3_q_ff.x) - wide_type'(e3_item_ff.b.x));
         e4_vq_ff[1].y <= sat_fix(wide_type'(e3_q_ff.y) - wide_type'(e3_item_ff.b.y));
         e4_vq_ff[1].z <= sat_fix(wide_type'(e3_q_ff.z) - wide_type'(e3_item_ff.b.z));
         e4_vq_ff[2].x <= sat_fix(wide_type'(e3_q_ff.x) - wide_type'(e3_item_ff.c.x));
         e4_vq_ff[2].y <= sat_fix(wide_type'(e3_q_ff.y) - wide_type'(e3_item_ff.c.y));
         e4_vq_ff[2].z <= sat_fix(wide_type'(e3_q_ff.z) - wide_type'(e3_item_ff.c.z));
      end
   end

   // edge AB pairs with Q-A, BC with Q-B, CA with Q-C
   assign side_v[0] = e4_item_ff.ab;
   assign side_v[1] = e4_item_ff.bc;
   assign side_v[2] = e4_item_ff.ca;

   // stages 5 to 7 are per edge
   for (genvar k = 0; k < 3; k++) begin : g_side
      // stage 5: cross product partial products
      always_ff @(posedge clock) begin
         if (en) begin
            e5_p_ff[k][0] <= side_v[k].y * e4_vq_ff[k].z;
            e5_p_ff[k][1] <= side_v[k].z * e4_vq_ff[k].y;
            e5_p_ff[k][2] <= side_v[k].z * e4_vq_ff[k].x;
            e5_p_ff[k][3] <= side_v[k].x * e4_vq_ff[k].z;
            e5_p_ff[k][4] <= side_v[k].x * e4_vq_ff[k].y;
            e5_p_ff[k][5] <= side_v[k].y * e4_vq_ff[k].x;
         end
      end

      // stage 6: cross product
      always_ff @(posedge clock) begin
         if (en) begin
            e6_x_ff[k].x <= rescale(wide_type'(e5_p_ff[k][0]) - wide_type'(e5_p_ff[k][1]));
            e6_x_ff[k].y <= rescale(wide_type'(e5_p_ff[k][2]) - wide_type'(e5_p_ff[k][3]));
            e6_x_ff[k].z <= rescale(wide_type'(e5_p_ff[k][4]) - wide_type'(e5_p_ff[k][5]));
         end
      end

      // stage 7: dot with the normal, exact
      always_ff @(posedge clock) begin
         if (en) begin
            e7_p_ff[k][0] <= e6_x_ff[k].x * e6_item_ff.n.x;
            e7_p_ff[k][1] <= e6_x_ff[k].y * e6_item_ff.n.y;
            e7_p_ff[k][2] <= e6_x_ff[k].z * e6_item_ff.n.z;
         end
      end

      // zero counts as inside
      wide_type dot_sum;
      assign dot_sum    = wide_type'(e7_p_ff[k][0]) + wide_type'(e7_p_ff[k][1])
                          + wide_type'(e7_p_ff[k][2]);
      assign side_ok[k] = !dot_sum[WIDE_BITS-1];
   end

   // payload alongside the edge stages
   always_ff @(posedge clock) begin
      if (en) begin
         e5_item_ff <= e4_item_ff;
         e5_ok_ff   <= e4_ok_ff;
         e6_item_ff <= e5_item_ff;
         e6_ok_ff   <= e5_ok_ff;
         e7_item_ff <= e6_item_ff;
         e7_ok_ff   <= e6_ok_ff;
      end
   end

   // stage 8: output register
   always_ff @(posedge clock) begin
      if (en) begin
         e8_hit_ff <= e7_ok_ff & side_ok[0] & side_ok[1] & side_ok[2];
         e8_px_ff  <= e7_item_ff.px;
         e8_py_ff  <= e7_item_ff.py;
      end
   end

   assign out_valid = e8_valid_ff;
   assign out_hit   = e8_hit_ff;
   assign out_px    = e8_px_ff;
   assign out_py    = e8_py_ff;

endmodule

FILE: hdl/ray_triangle_hit_test.sv
`timescale 1ns / 1ps
`include "ray_triangle_hit_test_defines.svh"
// Ray / triangle hit test. One ray beat (three Q10.10 vertices, a ray
// direction and a pixel tag) is accepted every clock and one result beat
// (hit flag plus the same tag) comes out per ray, in order, after the front
// end for the normal and plane terms, the pipelined divider that forms t
// (one quotient bit per stage) and the stages for the hit point and edge-side
// tests on AB, BC and CA. The whole pipe advances together; it holds only
// while a result beat sits unaccepted at the output, and then req.ready is low.
// Camera registers are written through csr_we/csr_index/csr_wdata (index 0
// to 2 for x, y, z; reset 0) and must only change while no ray is in flight.
// A ray parallel to the triangle plane, or a degenerate triangle, is a miss.
module ray_triangle_hit_test import rth_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]   csr_wdata,
   rth_req_if.sink                 req,
   rth_rsp_if.source               rsp
);

   cvec_type    camera_ff;
   logic        advance;
   logic        front_valid;
   div_in_type  front_div;
   logic        div_valid;
   div_out_type div_out;

   // camera registers
   always_ff @(posedge clock) begin
      if (reset) begin
         camera_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAMERA_X: begin
               camera_ff.x <= csr_wdata;
            end
            CSR_CAMERA_Y: begin
               camera_ff.y <= csr_wdata;
            end
            CSR_CAMERA_Z: begin
               camera_ff.z <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // pipe moves unless the output beat is held
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   rth_front u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (advance),
      .in_valid      (req.valid),
      .vertex_a      (req.vertex_a),
      .vertex_b      (req.vertex_b),
      .vertex_c      (req.vertex_c),
      .ray_direction (req.ray_direction),
      .pixel_x       (req.pixel_x),
      .pixel_y       (req.pixel_y),
      .camera        (camera_ff),
      .out_valid     (front_valid),
      .out_div       (front_div)
   );

   rth_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (front_valid),
      .in_div    (front_div),
      .out_valid (div_valid),
      .out_div   (div_out)
   );

   rth_side_test u_side_test (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (div_valid),
      .in_div    (div_out),
      .camera    (camera_ff),
      .out_valid (rsp.valid),
      .out_hit   (rsp.hit),
      .out_px    (rsp.out_pixel_x),
      .out_py    (rsp.out_pixel_y)
   );

   // checks
   `RTH_ASSERT_SAME(a_no_take_on_stall, clock, reset, rsp.valid && !rsp.ready, !req.ready, "ray beat taken while result held")
   `RTH_ASSERT_NEXT(a_pipe_frozen, clock, reset, rsp.valid && !rsp.ready, $stable(div_valid), "pipe moved during output stall")
   `RTH_ASSERT_SAME(a_empty_after_reset, clock, reset, $past(reset), !rsp.valid, "result beat right after reset")

endmodule

FILE: sim/ray_triangle_hit_test_tb.sv
`timescale 1ns / 1ps
module ray_triangle_hit_test_tb import rth_pkg::*; ();

   typedef struct {
      longint x;
      longint y;
      longint z;
   } v3_type;

   typedef struct {
      bit                  hit;
      logic [TAG_BITS-1:0] px;
      logic [TAG_BITS-1:0] py;
   } hit_result_type;

   localparam longint FIXED_HI = 64'sd1073741823;
   localparam longint FIXED_LO = -64'sd1073741824;
   localparam longint CMAX     = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
   localparam longint CMIN     = -(64'sd1 <<< (COORD_BITS - 1));

   // Hit predictor and the queue of hit results still owed by the block
   class hit_scoreboard;
      longint         cam_x, cam_y, cam_z;
      hit_result_type owed[$];
      int             errors;

      function longint sat(longint v);
         return v > FIXED_HI ? FIXED_HI : (v < FIXED_LO ? FIXED_LO : v);
      endfunction

      function longint rescale(longint v);
         return sat(v >>> FRAC_BITS);
      endfunction

      function longint sext(logic [COORD_BITS-1:0] raw);
         return longint'($signed(raw));
      endfunction

      function v3_type unpack_vec(logic [VEC_BITS-1:0] w);
         v3_type r;
         r.x = sext(w[COORD_BITS-1:0]);
         r.y = sext(w[2*COORD_BITS-1:COORD_BITS]);
         r.z = sext(w[VEC_BITS-1:2*COORD_BITS]);
         return r;
      endfunction

      function v3_type vsub(v3_type a, v3_type b);
         v3_type r;
         r.x = sat(a.x - b.x);
         r.y = sat(a.y - b.y);
         r.z = sat(a.z - b.z);
         return r;
      endfunction

      function v3_type vcross(v3_type a, v3_type b);
         v3_type r;
         r.x = rescale(a.y * b.z - a.z * b.y);
         r.y = rescale(a.z * b.x - a.x * b.z);
         r.z = rescale(a.x * b.y - a.y * b.x);
         return r;
      endfunction

      function longint vdot(v3_type a, v3_type b);
         return a.x * b.x + a.y * b.y + a.z * b.z;
      endfunction

      // zero counts as inside
      function bit inside_edge(v3_type e, v3_type vq, v3_type n);
         return vdot(vcross(e, vq), n) >= 0;
      endfunction

      function void set_camera(csr_index_type idx, logic [COORD_BITS-1:0] val);
         case (idx)
            CSR_CAMERA_X: cam_x = sext(val);
            CSR_CAMERA_Y: cam_y = sext(val);
            CSR_CAMERA_Z: cam_z = sext(val);
            default: ;
         endcase
      endfunction

      function void note_ray(logic [VEC_BITS-1:0] wa, logic [VEC_BITS-1:0] wb,
                             logic [VEC_BITS-1:0] wc, logic [VEC_BITS-1:0] wd,
                             logic [TAG_BITS-1:0] px, logic [TAG_BITS-1:0] py);
         v3_type a, b, c, d, p, q, ab, ac, bc, ca, n;
         longint num, den, t;
         hit_result_type r;
         a = unpack_vec(wa);
         b = unpack_vec(wb);
         c = unpack_vec(wc);
         d = unpack_vec(wd);
         p.x = cam_x;
         p.y = cam_y;
         p.z = cam_z;
         ab = vsub(b, a);
         ac = vsub(c, a);
         bc = vsub(c, b);
         ca = vsub(a, c);
         n = vcross(ab, ac);
         num = sat(rescale(vdot(n, a)) - rescale(vdot(n, p)));
         den = rescale(vdot(n, d));
         r.hit = 0;
         r.px = px;
         r.py = py;
         // parallel ray or degenerate triangle is a miss
         if (den != 0) begin
            t = sat((num * (64'sd1 << FRAC_BITS)) / den);
            q.x = sat(p.x + rescale(d.x * t));
            q.y = sat(p.y + rescale(d.y * t));
            q.z = sat(p.z + rescale(d.z * t));
            r.hit = inside_edge(ab, vsub(q, a), n) && inside_edge(bc, vsub(q, b), n)
                    && inside_edge(ca, vsub(q, c), n);
         end
         owed.push_back(r);
      endfunction

      task report(string what);
         errors++;
         $display("error at %0t: %s", $time, what);
      endtask

      task check_result(logic hit, logic [TAG_BITS-1:0] px, logic [TAG_BITS-1:0] py);
         hit_result_type e;
         if (owed.size() == 0) begin
            report($sformatf("unexpected result beat hit=%0b px=%0d py=%0d", hit, px, py));
            return;
         end
         e = owed.pop_front();
         if (hit !== e.hit)
            report($sformatf("hit %0b, expected %0b (px=%0d py=%0d)", hit, e.hit, e.px, e.py));
         if (px !== e.px)
            report($sformatf("out_pixel_x %0d, expected %0d", px, e.px));
         if (py !== e.py)
            report($sformatf("out_pixel_y %0d, expected %0d", py, e.py));
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [COORD_BITS-1:0]   csr_wdata;

   rth_req_if req ();
   rth_rsp_if rsp ();

   ray_triangle_hit_test dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req.sink),
      .rsp       (rsp.source)
   );

   hit_scoreboard sb;
   int            send_idle_pct;
   int            recv_stall_pct;
   v3_type        cam;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("ray_triangle_hit_test: mismatch");
      $finish;
   end

   // Result side: check each accepted beat, then pick next ready
   initial begin
      rsp.ready <= 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready)
            sb.check_result(rsp.hit, rsp.out_pixel_x, rsp.out_pixel_y);
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function logic [VEC_BITS-1:0] pack_vec(v3_type v);
      return {v.z[COORD_BITS-1:0], v.y[COORD_BITS-1:0], v.x[COORD_BITS-1:0]};
   endfunction

   function v3_type mkv(longint x, longint y, longint z);
      v3_type r;
      r.x = x;
      r.y = y;
      r.z = z;
      return r;
   endfunction

   function longint rnd_coord(int span);
      return longint'($urandom_range(2 * span)) - span;
   endfunction

   function v3_type rnd_vec(int span);
      return mkv(rnd_coord(span), rnd_coord(span), rnd_coord(span));
   endfunction

   task csr_write(csr_index_type idx, longint val);
      @(posedge clock);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val[COORD_BITS-1:0];
      sb.set_camera(idx, val[COORD_BITS-1:0]);
   endtask

   task set_camera(longint x, longint y, longint z);
      csr_write(CSR_CAMERA_X, x);
      csr_write(CSR_CAMERA_Y, y);
      csr_write(CSR_CAMERA_Z, z);
      @(posedge clock);
      csr_we <= 0;
      cam = mkv(x, y, z);
   endtask

   // Drive one ray beat and hold it until accepted
   task send_ray(logic [VEC_BITS-1:0] a, logic [VEC_BITS-1:0] b, logic [VEC_BITS-1:0] c,
                 logic [VEC_BITS-1:0] d, logic [TAG_BITS-1:0] px, logic [TAG_BITS-1:0] py);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid         <= 1;
      req.vertex_a      <= a;
      req.vertex_b      <= b;
      req.vertex_c      <= c;
      req.ray_direction <= d;
      req.pixel_x       <= px;
      req.pixel_y       <= py;
      do @(posedge clock); while (!req.ready);
      sb.note_ray(a, b, c, d, px, py);
   endtask

   task send_vecs(v3_type a, v3_type b, v3_type c, v3_type d);
      send_ray(pack_vec(a), pack_vec(b), pack_vec(c), pack_vec(d),
               TAG_BITS'($urandom_range(4095)), TAG_BITS'($urandom_range(4095)));
   endtask

   // Ray from the camera aimed at a barycentric mix of the corners;
   // a negative weight puts the target outside, flip sends it backwards
   task send_aimed(int span, bit outside, bit flip);
      v3_type a, b, c, tg, d;
      longint w0, w1, w2, s;
      a = rnd_vec(span);
      b = rnd_vec(span);
      c = rnd_vec(span);
      w0 = longint'($urandom_range(255));
      w1 = longint'($urandom_range(255));
      w2 = longint'($urandom_range(255));
      if (outside)
         w0 = -w0 - 1;
      s = w0 + w1 + w2;
      if (s == 0)
         s = 1;
      tg = mkv((w0 * a.x + w1 * b.x + w2 * c.x) / s, (w0 * a.y + w1 * b.y + w2 * c.y) / s,
               (w0 * a.z + w1 * b.z + w2 * c.z) / s);
      d = mkv(tg.x - cam.x, tg.y - cam.y, tg.z - cam.z);
      while (d.x > CMAX || d.x < CMIN || d.y > CMAX || d.y < CMIN || d.z > CMAX || d.z < CMIN)
         d = mkv(d.x >>> 1, d.y >>> 1, d.z >>> 1);
      if (flip)
         d = mkv(-d.x, -d.y, -d.z);
      send_vecs(a, b, c, d);
   endtask

   task send_random_ray();
      send_ray(VEC_BITS'({$urandom, $urandom}), VEC_BITS'({$urandom, $urandom}),
               VEC_BITS'({$urandom, $urandom}), VEC_BITS'({$urandom, $urandom}),
               TAG_BITS'($urandom_range(4095)), TAG_BITS'($urandom_range(4095)));
   endtask

   task drain();
      req.valid <= 0;
      while (sb.owed.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task directed_rays();
      v3_type a, b, c;
      a = mkv(0, 0, 4096);
      b = mkv(4096, 0, 4096);
      c = mkv(0, 4096, 4096);
      // all zeros: degenerate, parallel
      send_ray('0, '0, '0, '0, 0, 0);
      // all ones
      send_ray('1, '1, '1, '1, 4095, 4095);
      // clean hit and its reversed ray, which still hits
      send_vecs(a, b, c, mkv(1024, 1024, 4096));
      send_vecs(a, b, c, mkv(-1024, -1024, -4096));
      // clear miss
      send_vecs(a, b, c, mkv(8192, 8192, 4096));
      // ray lying parallel to the plane
      send_vecs(a, b, c, mkv(1024, 1024, 0));
      // degenerate triangle
      send_vecs(a, a, a, mkv(0, 0, 1024));
      // through a corner and along an edge
      send_vecs(a, b, c, mkv(0, 0, 4096));
      send_vecs(a, b, c, mkv(2048, 0, 4096));
      send_vecs(a, b, c, mkv(2048, 2048, 4096));
      // coordinate extremes, saturating intermediates
      send_vecs(mkv(CMAX, CMIN, CMAX), mkv(CMIN, CMAX, CMIN), mkv(CMAX, CMAX, CMIN),
                mkv(CMIN, CMIN, CMAX));
      send_vecs(mkv(CMIN, CMIN, CMIN), mkv(CMAX, CMIN, CMIN), mkv(CMIN, CMAX, CMIN),
                mkv(1, 1, CMAX));
      send_vecs(mkv(CMAX, 0, 0), mkv(0, CMAX, 0), mkv(0, 0, CMAX), mkv(CMAX, CMAX, CMAX));
      send_vecs(mkv(CMIN, 0, 0), mkv(0, CMIN, 0), mkv(0, 0, CMIN), mkv(CMIN, CMIN, CMIN));
      send_vecs(a, b, c, mkv(1, 1, 1));
      send_ray('0, '0, '0, '0, 4095, 0);
      send_ray('1, '0, '1, '0, 0, 4095);
   endtask

   task run_phase(int mode, int n);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
         default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      repeat (n) begin
         int pick;
         pick = $urandom_range(99);
         if (pick < 55)
            send_aimed($urandom_range(1) ? 4096 : 65536, 0, pick < 8);
         else if (pick < 75)
            send_aimed(8192, 1, pick < 60);
         else
            send_random_ray();
      end
      drain();
   endtask

   initial begin
      sb = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      cam = mkv(0, 0, 0);
      reset     <= 1;
      csr_we    <= 0;
      csr_index <= CSR_CAMERA_X;
      csr_wdata <= '0;
      req.valid <= 0;
      req.vertex_a      <= '0;
      req.vertex_b      <= '0;
      req.vertex_c      <= '0;
      req.ray_direction <= '0;
      req.pixel_x       <= '0;
      req.pixel_y       <= '0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed rays from the reset camera
      directed_rays();
      drain();

      run_phase(0, 120);
      set_camera(CMAX, CMIN, CMAX);
      directed_rays();
      run_phase(1, 60);
      set_camera(CMIN, CMAX, CMIN);
      run_phase(2, 60);
      set_camera(rnd_coord(8192), rnd_coord(8192), rnd_coord(8192) - 40000);
      run_phase(3, 130);
      set_camera(rnd_coord(4096), rnd_coord(4096), rnd_coord(4096));
      run_phase(2, 110);
      set_camera(rnd_coord(2048), rnd_coord(2048), 30000);
      run_phase(1, 110);
      set_camera(0, 0, 0);
      run_phase(0, 110);

      if (sb.errors == 0)
         $display("ray_triangle_hit_test: match");
      else
         $display("ray_triangle_hit_test: mismatch");
      $finish;
   end
endmodule
